// File: hdl/double_ended_queue_top_defines.svh
// assertion macros for the double-ended queue checker
// no dependencies; included by the checker file
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/deq_pkg.sv
// shared types and constants for the double-ended queue
// no dependencies
`timescale 1ns / 1ps

package deq_pkg;

	localparam int DEPTH_DEF = 1024;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PEEK_FRONT = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_PUSH_BACK  = 3'd3,
		CMD_PEEK_BACK  = 3'd4,
		CMD_POP_BACK   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] peek_value;
		status_t            status;
		logic               has_data;
	} rsp_t;

	// result control carried from the command stage to the output
	typedef struct packed {
		logic    valid;
		status_t status;
		logic    has_data;
	} res_ctl_t;

endpackage

// File: hdl/deq_ram.sv
// ring storage for the double-ended queue, one write and one registered read port
// depends on deq_pkg
`timescale 1ns / 1ps

module deq_ram import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic signed [31:0]  wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic signed [31:0]  rd_data
);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/deq_ctrl.sv
// head and count tracking, command decode and memory addressing for the deque
// depends on deq_pkg
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW = $clog2(DEPTH),
	parameter int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  req_t          req,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	output res_ctl_t      ctl_s1
);

	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic          is_empty, is_full;
	logic [AW-1:0] head_dec, head_inc, tail_idx, back_idx;
	logic [AW:0]   tail_sum, back_sum;
	logic [CW-1:0] count_m1;
	status_t       status_c;
	logic          has_c, wr_c;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));
	assign count_m1 = count_q - CW'(1);

	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	// ring add modulo depth, both operands below depth
	assign tail_sum = {1'b0, head_q} + {1'b0, count_q[AW-1:0]};
	assign back_sum = {1'b0, head_q} + {1'b0, count_m1[AW-1:0]};
	assign tail_idx = (tail_sum >= (AW+1)'(DEPTH)) ?
		AW'(tail_sum - (AW+1)'(DEPTH)) : tail_sum[AW-1:0];
	assign back_idx = (back_sum >= (AW+1)'(DEPTH)) ?
		AW'(back_sum - (AW+1)'(DEPTH)) : back_sum[AW-1:0];

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		wr_c     = 1'b0;
		wr_addr  = tail_idx;
		rd_addr  = head_q;
		status_c = ST_OK;
		has_c    = 1'b0;
		case (req.cmd) inside
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (is_full) begin
					status_c = ST_FULL;
				end else begin
					wr_c    = 1'b1;
					count_d = count_q + CW'(1);
					if (req.cmd == CMD_PUSH_FRONT) begin
						head_d  = head_dec;
						wr_addr = head_dec;
					end
				end
			end
			CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
				if (is_empty) begin
					status_c = ST_EMPTY;
				end else begin
					has_c = 1'b1;
					if (req.cmd == CMD_PEEK_BACK) begin
						rd_addr = back_idx;
					end
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (is_empty) begin
					status_c = ST_EMPTY;
				end else begin
					count_d = count_m1;
					if (req.cmd == CMD_POP_FRONT) begin
						head_d = head_inc;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign wr_en = accept & wr_c;
	assign rd_en = accept & has_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			ctl_s1  <= '0;
		end else begin
			ctl_s1.valid <= accept;
			if (accept) begin
				head_q          <= head_d;
				count_q         <= count_d;
				ctl_s1.status   <= status_c;
				ctl_s1.has_data <= has_c;
			end
		end
	end

endmodule

// File: hdl/double_ended_queue_top.sv
// top level of the double-ended queue: command stage plus ring storage
// depends on deq_pkg, deq_ctrl and deq_ram
//
//   channel   | handshake            | payload
//   ----------+----------------------+--------
//   request   | start high, busy low | req (req_t)
//   result    | done, one cycle      | rsp (rsp_t)
//
// one request per cycle; its result shows in the cycle after acceptance,
// as the ring memory read port and the result control are both registered
// busy stays low, so a request can be taken at every edge
// reset clears head and count; memory contents are kept undefined until written
// the receiver takes each result in the cycle it is shown
`timescale 1ns / 1ps

module double_ended_queue_top import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic               accept;
	logic               wr_en, rd_en;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic signed [31:0] rd_data;
	res_ctl_t           ctl_s1;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	deq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.req     (req),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.ctl_s1  (ctl_s1)
	);

	deq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (req.push_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign done           = ctl_s1.valid;
	assign rsp.peek_value = ctl_s1.has_data ? rd_data : '0;
	assign rsp.status     = ctl_s1.status;
	assign rsp.has_data   = ctl_s1.has_data;

endmodule

// File: hdl/deq_checker.sv
// port-level checks for the double-ended queue, bound to the top level
// depends on deq_pkg and double_ended_queue_top_defines.svh
`timescale 1ns / 1ps
`include "double_ended_queue_top_defines.svh"

module deq_checker import deq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	`DEQ_ASSERT_NXT(a_req_gives_result, clk, arst_n, start && !busy, done, "no result")
	`DEQ_ASSERT_NXT(a_no_spurious_result, clk, arst_n, !(start && !busy), !done, "stray result")
	`DEQ_ASSERT_IMP(a_data_means_ok, clk, arst_n, done && rsp.has_data, rsp.status == ST_OK, "bad status")
	`DEQ_ASSERT_IMP(a_no_data_zero, clk, arst_n, done && !rsp.has_data, rsp.peek_value == '0, "stray value")

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for the double-ended queue: directed and random requests checked
// against a cycle-free predictor of the ring; depends on deq_pkg and double_ended_queue_top

module tb_top;
	import deq_pkg::*;

	localparam int SLOTS = DEPTH_DEF;
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 11;
	localparam int RAND_PER_PHASE = 214;
	localparam int LIMIT_NS = 1000000;
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	class deque_scoreboard;
		logic signed [31:0] ring [SLOTS];
		int head;
		int fill;
		rsp_t expected_q[$];
		int errors;
		int requests;
		int checked;
		int full_drops;
		int empty_hits;
		int data_hits;
		int peak_fill;

		function new();
			head = 0;
			fill = 0;
			errors = 0;
			requests = 0;
			checked = 0;
			full_drops = 0;
			empty_hits = 0;
			data_hits = 0;
			peak_fill = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		function void note_request(req_t r);
			rsp_t e;
			e = '0;
			e.status = ST_OK;
			requests++;
			case (r.cmd) inside
				CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
					if (fill >= SLOTS) begin
						e.status = ST_FULL;
						full_drops++;
					end else if (r.cmd == CMD_PUSH_FRONT) begin
						head = (head + SLOTS - 1) % SLOTS;
						ring[head] = r.push_value;
						fill++;
					end else begin
						ring[(head + fill) % SLOTS] = r.push_value;
						fill++;
					end
				end
				CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
					if (fill == 0) begin
						e.status = ST_EMPTY;
						empty_hits++;
					end else begin
						e.has_data = 1'b1;
						data_hits++;
						if (r.cmd == CMD_PEEK_FRONT) begin
							e.peek_value = ring[head];
						end else begin
							e.peek_value = ring[(head + fill - 1) % SLOTS];
						end
					end
				end
				CMD_POP_FRONT, CMD_POP_BACK: begin
					if (fill == 0) begin
						e.status = ST_EMPTY;
						empty_hits++;
					end else begin
						if (r.cmd == CMD_POP_FRONT) begin
							head = (head + 1) % SLOTS;
						end
						fill--;
					end
				end
				default: ;
			endcase
			if (fill > peak_fill) begin
				peak_fill = fill;
			end
			expected_q = {expected_q, e};
		endfunction

		task check_result(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				report("result with no pending request");
			end else begin
				e = expected_q.pop_front();
				checked++;
				if (got !== e) begin
					report($sformatf("got %0d/%0d/%0b, expected %0d/%0d/%0b",
						got.peek_value, got.status, got.has_data,
						e.peek_value, e.status, e.has_data));
				end
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	deque_scoreboard sb;

	always #HALF_PERIOD clk = ~clk;

	double_ended_queue_top #(
		.DEPTH (SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				sb.check_result(rsp);
			end
			if (start && !busy) begin
				sb.note_request(req);
			end
		end
	end

	task automatic send_req(input logic [2:0] code, input logic signed [31:0] value,
		input int idle_pct);
		req_t r;
		r.cmd = cmd_t'(code);
		r.push_value = value;
		while (int'($urandom_range(99)) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk iff !busy);
	endtask

	task automatic random_phase(input int count, input int idle_pct);
		int pick;
		logic [2:0] code;
		for (int i = 0; i < count; i++) begin
			pick = int'($urandom_range(99));
			if (pick < 15) begin
				code = CMD_PUSH_FRONT;
			end else if (pick < 30) begin
				code = CMD_PUSH_BACK;
			end else if (pick < 40) begin
				code = CMD_PEEK_FRONT;
			end else if (pick < 50) begin
				code = CMD_PEEK_BACK;
			end else if (pick < 72) begin
				code = CMD_POP_FRONT;
			end else if (pick < 94) begin
				code = CMD_POP_BACK;
			end else begin
				code = pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
			end
			send_req(code, $urandom(), idle_pct);
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		start  <= 1'b0;
		req    <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty deque and unused codes
		send_req(CMD_PEEK_FRONT, '0, 0);
		send_req(CMD_PEEK_BACK, '0, 0);
		send_req(CMD_POP_FRONT, '0, 0);
		send_req(CMD_POP_BACK, '0, 0);
		send_req(CMD_SPARE_LO, 32'sh12345678, 0);
		send_req(CMD_SPARE_HI, -32'sd1, 0);

		// both ends with extreme words
		send_req(CMD_PUSH_BACK, 32'sh7fffffff, 0);
		send_req(CMD_PUSH_FRONT, 32'sh80000000, 0);
		send_req(CMD_PEEK_FRONT, '0, 0);
		send_req(CMD_PEEK_BACK, '0, 0);
		send_req(CMD_POP_BACK, '0, 0);
		send_req(CMD_PEEK_BACK, '0, 0);
		send_req(CMD_POP_FRONT, '0, 0);
		send_req(CMD_PEEK_FRONT, '0, 0);

		// fill to full and push past it
		for (int i = 0; i < SLOTS + 3; i++) begin
			send_req((i % 2 == 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom(), 0);
		end
		send_req(CMD_PEEK_FRONT, '0, 0);
		send_req(CMD_PEEK_BACK, '0, 0);

		random_phase(RAND_PER_PHASE, 0);
		random_phase(RAND_PER_PHASE, 84);
		random_phase(RAND_PER_PHASE, 0);
		random_phase(RAND_PER_PHASE, 10);

		start <= 1'b0;
		req   <= '0;
		repeat (4) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			sb.report("results missing at end of run");
		end

		$display("%0d requests, %0d results checked, %0d mismatches",
			sb.requests, sb.checked, sb.errors);
		$display("full drops %0d, empty hits %0d, peeks with data %0d, peak fill %0d",
			sb.full_drops, sb.empty_hits, sb.data_hits, sb.peak_fill);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#LIMIT_NS;
		$display("run exceeded its time limit");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/deq_ctrl.sv
hdl/double_ended_queue_top.sv
hdl/deq_checker.sv
bench/tb_top.sv
